/* hw/rtl/lrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lrc_pkg;

	localparam int OUT_W       = 48;
	localparam int QBITS       = OUT_W - 1;
	localparam int DEN_W       = 16;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES  = (QBITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	// entry register, step stages, sign/clamp register
	localparam int DIV_LAT     = DIV_STAGES + 2;

	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_FRAC_BITS  = 16;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef logic signed [OUT_W-1:0] fix_t;

	// control and corner data carried beside the dividers
	typedef struct packed {
		logic a_zero;
		logic b_zero;
		logic degen;
		fix_t fxl;
		fix_t fyl;
		fix_t fxh;
		fix_t fyh;
	} side_t;

endpackage
`default_nettype wire

/* hw/rtl/lrc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module lrc_div #(
	parameter int NW = 120
) (
	input  wire logic                       clk,
	input  wire logic [NW-1:0]              n_mag,
	input  wire logic [lrc_pkg::DEN_W-1:0]  d_mag,
	input  wire logic                       neg,
	output lrc_pkg::fix_t                   quot
);
	import lrc_pkg::*;

	logic [DEN_W-1:0] rem_s [0:DIV_STAGES];
	logic [QBITS-1:0] wrk_s [0:DIV_STAGES];
	logic [DEN_W-1:0] den_s [0:DIV_STAGES];
	logic             ovf_s [0:DIV_STAGES];
	logic             neg_s [0:DIV_STAGES];

	logic [NW-QBITS-1:0] top_n;
	assign top_n = n_mag[NW-1:QBITS];

	// quotient >= 2^47 iff the bits above the low 47 reach the divisor
	always_ff @(posedge clk) begin
		ovf_s[0] <= (top_n >= (NW-QBITS)'(d_mag));
		rem_s[0] <= top_n[DEN_W-1:0];
		wrk_s[0] <= n_mag[QBITS-1:0];
		den_s[0] <= d_mag;
		neg_s[0] <= neg;
	end

	genvar g;
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_stage
			logic [DEN_W-1:0] r_nx;
			logic [QBITS-1:0] w_nx;
			always_comb begin
				logic [DEN_W:0] t;
				logic           qb;
				r_nx = rem_s[g];
				w_nx = wrk_s[g];
				for (int k = 0; k < STEPS_PER_STAGE; k++) begin
					if (g * STEPS_PER_STAGE + k < QBITS) begin
						t  = {r_nx, w_nx[QBITS-1]};
						qb = (t >= {1'b0, den_s[g]});
						if (qb) begin
							t = t - {1'b0, den_s[g]};
						end
						r_nx = t[DEN_W-1:0];
						w_nx = {w_nx[QBITS-2:0], qb};
					end
				end
			end
			always_ff @(posedge clk) begin
				rem_s[g+1] <= r_nx;
				wrk_s[g+1] <= w_nx;
				den_s[g+1] <= den_s[g];
				ovf_s[g+1] <= ovf_s[g];
				neg_s[g+1] <= neg_s[g];
			end
		end
	endgenerate

	// sign and saturate
	always_ff @(posedge clk) begin
		if (ovf_s[DIV_STAGES]) begin
			quot <= neg_s[DIV_STAGES] ? OUT_MIN : OUT_MAX;
		end else if (neg_s[DIV_STAGES]) begin
			quot <= -fix_t'({1'b0, wrk_s[DIV_STAGES]});
		end else begin
			quot <= fix_t'({1'b0, wrk_s[DIV_STAGES]});
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/line_rectangle_clip_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// A start transfer passes the capture, product, numerator, divider, point and output registers to done.
// Throughput: one line per cycle; busy is always low, nothing stalls.
// Four 47-step restoring dividers, four quotient bits per stage, set the depth.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
// The result is shown for one cycle with done; the receiver cannot stall.
module line_rectangle_clip_core #(
	parameter int COORD_BITS = lrc_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = lrc_pkg::DEF_FRAC_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [15:0]           coef_a,
	input  wire logic signed [15:0]           coef_b,
	input  wire logic signed [31:0]           coef_c,
	input  wire logic signed [COORD_BITS-1:0] corner1_x,
	input  wire logic signed [COORD_BITS-1:0] corner1_y,
	input  wire logic signed [COORD_BITS-1:0] corner2_x,
	input  wire logic signed [COORD_BITS-1:0] corner2_y,
	output logic                              done,
	output lrc_pkg::fix_t                     start_x,
	output lrc_pkg::fix_t                     start_y,
	output lrc_pkg::fix_t                     end_x,
	output lrc_pkg::fix_t                     end_y,
	output logic                              degenerate
);
	import lrc_pkg::*;

	localparam int PRODW = 16 + COORD_BITS;
	localparam int NUMW  = ((PRODW > 32) ? PRODW : 32) + 1;
	localparam int NW    = NUMW + FRAC_BITS + OUT_W;
	localparam int SHW   = COORD_BITS + FRAC_BITS;
	localparam int XW    = (SHW > OUT_W) ? SHW : OUT_W;
	localparam int LAT   = DIV_LAT + 5;

	// no backpressure anywhere: a transfer every cycle is fine
	assign busy = 1'b0;

	// corner to fixed point, saturated to the output range
	function automatic fix_t to_fix(input logic signed [COORD_BITS-1:0] v);
		logic signed [SHW-1:0] sh;
		logic signed [XW-1:0]  ext;
		sh  = SHW'(v) <<< FRAC_BITS;
		ext = XW'(sh);
		if (ext > XW'(OUT_MAX)) begin
			return OUT_MAX;
		end else if (ext < XW'(OUT_MIN)) begin
			return OUT_MIN;
		end
		return ext[OUT_W-1:0];
	endfunction

	// ---------------- stage 1: capture ----------------
	logic                          vld_s1;
	logic signed [15:0]            a_s1, b_s1;
	logic signed [31:0]            c_s1;
	logic signed [COORD_BITS-1:0]  x1_s1, y1_s1, x2_s1, y2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= coef_a;
		b_s1  <= coef_b;
		c_s1  <= coef_c;
		x1_s1 <= corner1_x;
		y1_s1 <= corner1_y;
		x2_s1 <= corner2_x;
		y2_s1 <= corner2_y;
	end

	// ---------------- stage 2: order corners, products ----------------
	logic signed [COORD_BITS-1:0] xl, xh, yl, yh;
	assign xl = (x1_s1 < x2_s1) ? x1_s1 : x2_s1;
	assign xh = (x1_s1 < x2_s1) ? x2_s1 : x1_s1;
	assign yl = (y1_s1 < y2_s1) ? y1_s1 : y2_s1;
	assign yh = (y1_s1 < y2_s1) ? y2_s1 : y1_s1;

	logic                     vld_s2;
	logic signed [15:0]       a_s2, b_s2;
	logic signed [31:0]       c_s2;
	logic signed [PRODW-1:0]  pl_s2, ph_s2, pt_s2, pb_s2;
	fix_t                     fxl_s2, fyl_s2, fxh_s2, fyh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		c_s2   <= c_s1;
		pl_s2  <= PRODW'(a_s1) * PRODW'(xl);
		ph_s2  <= PRODW'(a_s1) * PRODW'(xh);
		pt_s2  <= PRODW'(b_s1) * PRODW'(yl);
		pb_s2  <= PRODW'(b_s1) * PRODW'(yh);
		fxl_s2 <= to_fix(xl);
		fyl_s2 <= to_fix(yl);
		fxh_s2 <= to_fix(xh);
		fyh_s2 <= to_fix(yh);
	end

	// ---------------- stage 3: numerators, magnitudes, signs ----------------
	logic signed [NUMW-1:0] sum_l, sum_h, sum_t, sum_b;
	assign sum_l = NUMW'(pl_s2) + NUMW'(c_s2);
	assign sum_h = NUMW'(ph_s2) + NUMW'(c_s2);
	assign sum_t = NUMW'(pt_s2) + NUMW'(c_s2);
	assign sum_b = NUMW'(pb_s2) + NUMW'(c_s2);

	function automatic logic [NW-1:0] num_fix(input logic signed [NUMW-1:0] s);
		logic [NUMW-1:0] m;
		m = s[NUMW-1] ? NUMW'(-s) : NUMW'(s);
		return NW'(m) << FRAC_BITS;
	endfunction

	// quotient of -(sum)/den is negative when sum > 0 and den > 0, or the reverse
	function automatic logic quot_neg(input logic signed [NUMW-1:0] s, input logic dsign);
		return (!s[NUMW-1] && (s != '0)) ^ dsign;
	endfunction

	logic              vld_s3;
	logic [NW-1:0]     nl_s3, nh_s3, nt_s3, nb_s3;
	logic [DEN_W-1:0]  da_s3, db_s3;
	logic              gl_s3, gh_s3, gt_s3, gb_s3;
	side_t             side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		nl_s3 <= num_fix(sum_l);
		nh_s3 <= num_fix(sum_h);
		nt_s3 <= num_fix(sum_t);
		nb_s3 <= num_fix(sum_b);
		da_s3 <= a_s2[15] ? DEN_W'(-a_s2) : DEN_W'(a_s2);
		db_s3 <= b_s2[15] ? DEN_W'(-b_s2) : DEN_W'(b_s2);
		gl_s3 <= quot_neg(sum_l, b_s2[15]);
		gh_s3 <= quot_neg(sum_h, b_s2[15]);
		gt_s3 <= quot_neg(sum_t, a_s2[15]);
		gb_s3 <= quot_neg(sum_b, a_s2[15]);
		side_s3.a_zero <= (a_s2 == '0);
		side_s3.b_zero <= (b_s2 == '0);
		side_s3.degen  <= (a_s2 == '0) && (b_s2 == '0);
		side_s3.fxl    <= fxl_s2;
		side_s3.fyl    <= fyl_s2;
		side_s3.fxh    <= fxh_s2;
		side_s3.fyh    <= fyh_s2;
	end

	// ---------------- dividers: left, right (by b), top, bottom (by a) ----------------
	fix_t q_left, q_right, q_top, q_bot;

	lrc_div #(.NW(NW)) u_div_left (
		.clk(clk), .n_mag(nl_s3), .d_mag(db_s3), .neg(gl_s3), .quot(q_left)
	);
	lrc_div #(.NW(NW)) u_div_right (
		.clk(clk), .n_mag(nh_s3), .d_mag(db_s3), .neg(gh_s3), .quot(q_right)
	);
	lrc_div #(.NW(NW)) u_div_top (
		.clk(clk), .n_mag(nt_s3), .d_mag(da_s3), .neg(gt_s3), .quot(q_top)
	);
	lrc_div #(.NW(NW)) u_div_bot (
		.clk(clk), .n_mag(nb_s3), .d_mag(da_s3), .neg(gb_s3), .quot(q_bot)
	);

	// side data and valid delay matched to the divider depth
	logic  vld_q  [0:DIV_LAT-1];
	side_t side_q [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= vld_s3;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s3;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	side_t sd;
	assign sd = side_q[DIV_LAT-1];

	// ---------------- stage r1: build the four points ----------------
	// order: 0 left, 1 top, 2 right, 3 bottom; missing crossings keep a corner
	logic  vld_s4;
	logic  az_s4, bz_s4, dg_s4;
	fix_t  px_s4 [0:3];
	fix_t  py_s4 [0:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		az_s4    <= sd.a_zero;
		bz_s4    <= sd.b_zero;
		dg_s4    <= sd.degen;
		px_s4[0] <= sd.fxl;
		py_s4[0] <= sd.b_zero ? sd.fyl : q_left;
		px_s4[1] <= sd.a_zero ? sd.fxl : q_top;
		py_s4[1] <= sd.fyl;
		px_s4[2] <= sd.fxh;
		py_s4[2] <= sd.b_zero ? sd.fyh : q_right;
		px_s4[3] <= sd.a_zero ? sd.fxh : q_bot;
		py_s4[3] <= sd.fyh;
	end

	// ---------------- stage r2: rank by x and pick the result ----------------
	// pair (i, j), i earlier: j ranks up if x_i <= x_j, else i ranks up
	logic       le01, le02, le03, le12, le13, le23;
	logic [1:0] rk [0:3];

	assign le01 = px_s4[0] <= px_s4[1];
	assign le02 = px_s4[0] <= px_s4[2];
	assign le03 = px_s4[0] <= px_s4[3];
	assign le12 = px_s4[1] <= px_s4[2];
	assign le13 = px_s4[1] <= px_s4[3];
	assign le23 = px_s4[2] <= px_s4[3];

	assign rk[0] = 2'(!le01) + 2'(!le02) + 2'(!le03);
	assign rk[1] = 2'(le01)  + 2'(!le12) + 2'(!le13);
	assign rk[2] = 2'(le02)  + 2'(le12)  + 2'(!le23);
	assign rk[3] = 2'(le03)  + 2'(le13)  + 2'(le23);

	fix_t sx_n, sy_n, ex_n, ey_n;

	always_comb begin
		sx_n = '0;
		sy_n = '0;
		ex_n = '0;
		ey_n = '0;
		if (dg_s4) begin
			// both coefficients zero: all points zero
		end else if (az_s4) begin
			sx_n = px_s4[0]; sy_n = py_s4[0];
			ex_n = px_s4[2]; ey_n = py_s4[2];
		end else if (bz_s4) begin
			sx_n = px_s4[1]; sy_n = py_s4[1];
			ex_n = px_s4[3]; ey_n = py_s4[3];
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (rk[i] == 2'd1) begin
					sx_n = px_s4[i];
					sy_n = py_s4[i];
				end
				if (rk[i] == 2'd2) begin
					ex_n = px_s4[i];
					ey_n = py_s4[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		start_x    <= sx_n;
		start_y    <= sy_n;
		end_x      <= ex_n;
		end_y      <= ey_n;
		degenerate <= dg_s4;
	end

	// ---------------- checks ----------------
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("transfer did not produce a result after the pipeline depth");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without a matching start transfer");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |->
			(start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0))
		else $error("degenerate line returned nonzero points");

	a_horiz_order: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && az_s4 && !dg_s4) |=> (start_x <= end_x))
		else $error("horizontal line points out of x order");

endmodule
`default_nettype wire
